[design/rfo_pkg.sv]
// shared types and constants for the overwrite ring fifo
package rfo_pkg;

  localparam int unsigned Depth  = 16;
  localparam int unsigned DataW  = 32;
  localparam int unsigned CountW = $clog2(Depth + 1);
  localparam int unsigned InDataW  = ((DataW + 7) / 8) * 8;
  localparam int unsigned OutBits  = 1 + DataW + 1 + CountW + 1 + 1;
  localparam int unsigned OutDataW = ((OutBits + 7) / 8) * 8;

  typedef enum logic [1:0] {
    KindPush = 2'd0,
    KindEnq  = 2'd1,
    KindPop  = 2'd2,
    KindDeq  = 2'd3
  } kind_e;

  // per-cell control from the fifo controller
  typedef struct packed {
    logic shift;
    logic load;
  } cell_ctrl_t;

  // one result, lowest field last in the packing order
  typedef struct packed {
    logic              is_full;
    logic              is_empty;
    logic [CountW-1:0] count;
    logic              dropped_oldest;
    logic [DataW-1:0]  data_out;
    logic              ok;
  } result_t;

endpackage

[design/rfo_cell.sv]
// one storage cell of the shifting fifo chain
module rfo_cell (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  rfo_pkg::cell_ctrl_t       ctrl_i,
  input  logic [rfo_pkg::DataW-1:0] next_data_i,
  input  logic [rfo_pkg::DataW-1:0] load_data_i,
  output logic [rfo_pkg::DataW-1:0] data_o
);

  logic [rfo_pkg::DataW-1:0] data_q;
  logic [rfo_pkg::DataW-1:0] data_d;

  // load wins: when the store slot is also refilled by the shift, the load takes priority
  always_comb begin
    data_d = data_q;
    if (ctrl_i.load) begin
      data_d = load_data_i;
    end else if (ctrl_i.shift) begin
      data_d = next_data_i;
    end
  end

  // payload clears on reset, the value is never observed before a write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      data_q <= '0;
    end else begin
      data_q <= data_d;
    end
  end

  assign data_o = data_q;

endmodule

[design/ring_fifo_with_overwrite.sv]
// a result is registered and appears in the cycle after its operation is transferred
// throughput: one operation per cycle unless a result stalls; the output register frees as its result is taken
// storage is a row of cells, cell 0 the oldest; a removal shifts every cell down one place
// reset clears the occupancy count, the output valid and the cell contents
module ring_fifo_with_overwrite (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // operation channel
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [rfo_pkg::InDataW-1:0]     s_axis_tdata,  // [31:0] data_in
  input  logic [1:0]                      s_axis_tuser,  // [1:0] kind
  // result channel
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // [0] ok, [32:1] data_out, [33] dropped_oldest, [38:34] count,
  // [39] is_empty, [40] is_full, rest zero
  output logic [rfo_pkg::OutDataW-1:0]    m_axis_tdata
);

  localparam int unsigned Depth  = rfo_pkg::Depth;
  localparam int unsigned DataW  = rfo_pkg::DataW;
  localparam int unsigned CountW = rfo_pkg::CountW;

  // occupancy, the only control state of the storage
  logic [CountW-1:0] count_q;
  logic [CountW-1:0] count_d;

  // output register
  logic               out_valid_q;
  logic               out_valid_d;
  rfo_pkg::result_t   out_q;
  rfo_pkg::result_t   res;

  logic               accept;
  logic               is_full;
  logic               is_empty;
  logic               do_shift;
  logic               do_store;
  logic [CountW-1:0]  store_idx;
  rfo_pkg::kind_e     kind;

  logic [DataW-1:0]   cell_data [Depth];
  rfo_pkg::cell_ctrl_t cell_ctrl [Depth];

  // the output register is free when empty or being drained this cycle
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign kind     = rfo_pkg::kind_e'(s_axis_tuser);
  assign is_full  = (count_q == CountW'(Depth));
  assign is_empty = (count_q == '0);

  // operation decode
  always_comb begin
    do_shift           = 1'b0;
    do_store           = 1'b0;
    count_d            = count_q;
    res                = '0;
    unique case (kind)
      rfo_pkg::KindPush: begin
        do_store = 1'b1;
        res.ok   = 1'b1;
        if (is_full) begin
          // drop the oldest to make room, count stays at depth
          do_shift           = 1'b1;
          res.dropped_oldest = 1'b1;
        end else begin
          count_d = count_q + CountW'(1);
        end
      end
      rfo_pkg::KindEnq: begin
        if (!is_full) begin
          do_store = 1'b1;
          res.ok   = 1'b1;
          count_d  = count_q + CountW'(1);
        end
      end
      rfo_pkg::KindPop: begin
        if (!is_empty) begin
          do_shift = 1'b1;
          res.ok   = 1'b1;
          count_d  = count_q - CountW'(1);
        end
      end
      rfo_pkg::KindDeq: begin
        if (!is_empty) begin
          do_shift     = 1'b1;
          res.ok       = 1'b1;
          res.data_out = cell_data[0];
          count_d      = count_q - CountW'(1);
        end
      end
      default: begin
        res = '0;
      end
    endcase
    res.count    = count_d;
    res.is_empty = (count_d == '0);
    res.is_full  = (count_d == CountW'(Depth));
  end

  // new word lands just past the last valid entry, after any shift
  assign store_idx = do_shift ? (count_q - CountW'(1)) : count_q;

  // cell chain: each cell but the top takes its upper neighbor on a shift; the top keeps its own value
  for (genvar i = 0; i < Depth; i++) begin : g_cell
    logic [DataW-1:0] next_data;

    if (i == Depth - 1) begin : g_top
      assign next_data = cell_data[i];
    end else begin : g_mid
      assign next_data = cell_data[i+1];
    end

    assign cell_ctrl[i].shift = accept && do_shift;
    assign cell_ctrl[i].load  = accept && do_store && (store_idx == CountW'(i));

    rfo_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (cell_ctrl[i]),
      .next_data_i (next_data),
      .load_data_i (s_axis_tdata[DataW-1:0]),
      .data_o      (cell_data[i])
    );
  end

  // output valid follows transfers on both sides
  always_comb begin
    out_valid_d = out_valid_q;
    if (accept) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (accept) begin
        count_q <= count_d;
      end
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = rfo_pkg::OutDataW'(out_q);

endmodule

[design/rfo_checker.sv]
// port-level checks for the overwrite ring fifo, bound to the top level
module rfo_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [rfo_pkg::OutDataW-1:0]  m_axis_tdata
);

  rfo_pkg::result_t r;
  assign r = rfo_pkg::result_t'(m_axis_tdata[rfo_pkg::OutBits-1:0]);

  // a stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // flags agree with the reported count
  a_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (r.is_empty == (r.count == '0)) &&
                      (r.is_full == (r.count == rfo_pkg::CountW'(rfo_pkg::Depth))))
    else $error("empty or full flag disagrees with count");

  // a failed operation returns no data and drops nothing
  a_fail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !r.ok |-> (r.data_out == '0) && !r.dropped_oldest)
    else $error("failed operation carries data or a drop");

  // an overwrite only happens on a successful push that leaves the fifo full
  a_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && r.dropped_oldest |-> r.ok && r.is_full && (r.data_out == '0))
    else $error("drop reported outside a full push");

endmodule

bind ring_fifo_with_overwrite rfo_checker u_rfo_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
